// ===== design/ultrasonic_ranger_sequencer_unit_assert.svh =====
// Assertion macros for the ultrasonic ranger sequencer unit.
`ifndef ULTRASONIC_RANGER_SEQUENCER_UNIT_ASSERT_SVH
`define ULTRASONIC_RANGER_SEQUENCER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define URS_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define URS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define URS_ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define URS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== design/urs_pkg.sv =====
`timescale 1ns / 1ps

package urs_pkg;

    localparam int CFG_WIDTH         = 24;
    localparam int COUNT_WIDTH_DEF   = 24;
    localparam int CFG_INDEX_WIDTH   = 2;
    localparam int MODE_WIDTH        = 3;

    localparam logic [CFG_WIDTH-1:0] TRIGGER_TICKS_RST = 24'd400;
    localparam logic [CFG_WIDTH-1:0] ECHO_TIMEOUT_RST  = 24'd1800000;
    localparam logic [CFG_WIDTH-1:0] HOLDOFF_TICKS_RST = 24'd500000;
    localparam logic [CFG_WIDTH-1:0] TIMEOUT_CODE      = '1;

    // register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TRIGGER_TICKS = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ECHO_TIMEOUT  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HOLDOFF_TICKS = 2'd2;

    // sequencer modes
    localparam logic [MODE_WIDTH-1:0] MODE_READY   = 3'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_PULSE   = 3'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_WAIT    = 3'd2;
    localparam logic [MODE_WIDTH-1:0] MODE_TIMING  = 3'd3;
    localparam logic [MODE_WIDTH-1:0] MODE_HOLDOFF = 3'd4;

    typedef struct packed {
        logic read_request;
        logic echo_level;
    } in_t;

    typedef struct packed {
        logic                 trigger_level;
        logic                 result_valid;
        logic [CFG_WIDTH-1:0] echo_count;
        logic                 timed_out;
        logic                 busy_res;
    } out_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] trigger_ticks;
        logic [CFG_WIDTH-1:0] echo_timeout_ticks;
        logic [CFG_WIDTH-1:0] holdoff_ticks;
    } cfg_t;

endpackage

// ===== design/ultrasonic_ranger_sequencer_unit.sv =====
`timescale 1ns / 1ps
// The output register holds each result from the cycle after its input transfer.
// Throughput: one item per cycle while s_ready is high; the sequencer state steps once per transfer.
// The output register frees s_ready whenever m_ready is high or the register is empty.
// Reset (aresetn low, synchronous) clears sequencer state and output valid, and
// restores the configuration registers to their defaults.

`include "ultrasonic_ranger_sequencer_unit_assert.svh"

module ultrasonic_ranger_sequencer_unit #(
    parameter int COUNT_WIDTH = urs_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  urs_pkg::in_t                        s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output urs_pkg::out_t                       m_data,
    input  logic                                cfg_we,
    input  logic [urs_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [urs_pkg::CFG_WIDTH-1:0]       cfg_wdata
);

    urs_pkg::cfg_t cfg_reg;
    urs_pkg::out_t result;
    urs_pkg::out_t m_data_reg;
    logic          m_valid_reg;
    logic          in_xfer;

    assign s_ready = !m_valid_reg || m_ready;
    assign in_xfer = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.trigger_ticks      <= urs_pkg::TRIGGER_TICKS_RST;
            cfg_reg.echo_timeout_ticks <= urs_pkg::ECHO_TIMEOUT_RST;
            cfg_reg.holdoff_ticks      <= urs_pkg::HOLDOFF_TICKS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                urs_pkg::REG_TRIGGER_TICKS: cfg_reg.trigger_ticks      <= cfg_wdata;
                urs_pkg::REG_ECHO_TIMEOUT:  cfg_reg.echo_timeout_ticks <= cfg_wdata;
                urs_pkg::REG_HOLDOFF_TICKS: cfg_reg.holdoff_ticks      <= cfg_wdata;
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    urs_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (in_xfer),
        .in_data (s_data),
        .cfg     (cfg_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_xfer) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `URS_ASSERT_IMPLIES(a_timeout_code, aclk, aresetn, m_valid && m_data.timed_out, m_data.result_valid && (&m_data.echo_count))
    `URS_ASSERT_IMPLIES(a_idle_fields_zero, aclk, aresetn, m_valid && !m_data.result_valid, (m_data.echo_count == '0) && !m_data.timed_out)
    `URS_ASSERT_IMPLIES(a_trigger_busy, aclk, aresetn, m_valid && m_data.trigger_level, m_data.busy_res)
    `URS_ASSERT_NEXT(a_result_follows, aclk, aresetn, in_xfer, m_valid)

endmodule

// ===== design/urs_core.sv =====
`timescale 1ns / 1ps

module urs_core #(
    parameter int COUNT_WIDTH = urs_pkg::COUNT_WIDTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           step,
    input  urs_pkg::in_t   in_data,
    input  urs_pkg::cfg_t  cfg,
    output urs_pkg::out_t  result
);

    logic [urs_pkg::MODE_WIDTH-1:0] mode_reg, mode_next;
    logic                           pending_reg, pending_next;
    logic [COUNT_WIDTH-1:0]         count_reg, count_next;
    logic                           echo_prev_reg;

    logic                           rise, fall, expire;
    logic                           res_valid, res_timeout;
    logic [urs_pkg::CFG_WIDTH-1:0]  res_count;

    assign rise   = in_data.echo_level & ~echo_prev_reg;
    assign fall   = ~in_data.echo_level & echo_prev_reg;
    assign expire = (count_reg[COUNT_WIDTH-1:1] == '0);

    always_comb begin
        mode_next    = mode_reg;
        pending_next = pending_reg;
        count_next   = count_reg;
        res_valid    = 1'b0;
        res_timeout  = 1'b0;
        res_count    = '0;

        // edges win over the countdown step
        if (rise) begin
            mode_next  = urs_pkg::MODE_TIMING;
            count_next = COUNT_WIDTH'(cfg.echo_timeout_ticks);
        end else if (fall) begin
            res_valid  = 1'b1;
            res_count  = urs_pkg::CFG_WIDTH'(count_reg);
            mode_next  = urs_pkg::MODE_HOLDOFF;
            count_next = COUNT_WIDTH'(cfg.holdoff_ticks);
        end else begin
            unique case (mode_reg)
                urs_pkg::MODE_PULSE: begin
                    if (!expire) begin
                        count_next = count_reg - 1'b1;
                    end else begin
                        mode_next  = urs_pkg::MODE_WAIT;
                        count_next = COUNT_WIDTH'(cfg.echo_timeout_ticks);
                    end
                end
                urs_pkg::MODE_WAIT, urs_pkg::MODE_TIMING: begin
                    if (!expire) begin
                        count_next = count_reg - 1'b1;
                    end else begin
                        res_valid   = 1'b1;
                        res_timeout = 1'b1;
                        res_count   = urs_pkg::TIMEOUT_CODE;
                        mode_next   = urs_pkg::MODE_READY;
                    end
                end
                urs_pkg::MODE_HOLDOFF: begin
                    if (!expire) begin
                        count_next = count_reg - 1'b1;
                    end else if (pending_reg) begin
                        pending_next = 1'b0;
                        mode_next    = urs_pkg::MODE_PULSE;
                        count_next   = COUNT_WIDTH'(cfg.trigger_ticks);
                    end else begin
                        mode_next = urs_pkg::MODE_READY;
                    end
                end
                default: begin
                    mode_next = urs_pkg::MODE_READY;
                end
            endcase
        end

        if (in_data.read_request) begin
            if (mode_next == urs_pkg::MODE_READY) begin
                pending_next = 1'b0;
                mode_next    = urs_pkg::MODE_PULSE;
                count_next   = COUNT_WIDTH'(cfg.trigger_ticks);
            end else if (mode_next == urs_pkg::MODE_HOLDOFF) begin
                pending_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= urs_pkg::MODE_READY;
            pending_reg   <= 1'b0;
            count_reg     <= '0;
            echo_prev_reg <= 1'b0;
        end else if (step) begin
            mode_reg      <= mode_next;
            pending_reg   <= pending_next;
            count_reg     <= count_next;
            echo_prev_reg <= in_data.echo_level;
        end
    end

    always_comb begin
        result.trigger_level = (mode_next == urs_pkg::MODE_PULSE);
        result.result_valid  = res_valid;
        result.echo_count    = res_count;
        result.timed_out     = res_timeout;
        result.busy_res      = (mode_next != urs_pkg::MODE_READY) &&
                               (mode_next != urs_pkg::MODE_HOLDOFF);
    end

endmodule
